/* sv/kbd_pkg.sv */
// ----------------------------------------------------------------------------
// kbd_pkg - keypad scanner shared types and constants
// Matrix geometry, register indexes, keymap reset values and the entry type
// that travels from the scan front end to the result back end.
// ----------------------------------------------------------------------------
package kbd_pkg;

	// matrix geometry, fixed by the port widths
	localparam int ROWS      = 4;
	localparam int COLUMNS   = 4;
	localparam int KEYS      = ROWS * COLUMNS;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int KEY_W     = ROW_W + COL_W;
	localparam int DRIVE_W   = 4;
	localparam int LEVEL_W   = 4;
	localparam int CODE_W    = 8;

	// configuration port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH = 2'd1;
	localparam logic [CFG_DATA_W-1:0] KEYMAP_LOW_RST  = 64'd2681389126241169969;
	localparam logic [CFG_DATA_W-1:0] KEYMAP_HIGH_RST = 64'd2813935235823646775;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified scan tick
	typedef struct packed {
		logic [COLUMNS-1:0] press_mask;
		logic [ROW_W-1:0]   row;
		logic [DRIVE_W-1:0] drive;
	} entry_t;

endpackage

/* sv/kbd_front.sv */
// ----------------------------------------------------------------------------
// kbd_front - scan tick intake and debounce
// Shifts the column levels into each key history of the driven row, updates
// stable states, finds new presses and pushes one entry per tick.
// ----------------------------------------------------------------------------
module kbd_front #(
	parameter int DEBOUNCE_SAMPLES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kbd_pkg::LEVEL_W-1:0]  column_levels,
	input  logic                         q_full,
	output logic                         q_push,
	output kbd_pkg::entry_t              q_entry
);
	import kbd_pkg::*;

	logic [DEBOUNCE_SAMPLES-1:0] hist_q [KEYS];
	logic [KEYS-1:0]             stable_q;
	logic [ROW_W-1:0]            row_q;

	logic [DEBOUNCE_SAMPLES-1:0] hist_new [COLUMNS];
	logic [COLUMNS-1:0]          all_low;
	logic [COLUMNS-1:0]          all_high;
	logic [COLUMNS-1:0]          press;
	logic [ROW_W-1:0]            row_next;
	logic                        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	// new history and press detection for the keys of the driven row
	always_comb begin
		for (int c = 0; c < COLUMNS; c++) begin
			hist_new[c] = {hist_q[{row_q, COL_W'(c)}][DEBOUNCE_SAMPLES-2:0], column_levels[c]};
			all_low[c]  = (hist_new[c] == '0);
			all_high[c] = (hist_new[c] == '1);
			press[c]    = all_low[c] && stable_q[{row_q, COL_W'(c)}];
		end
	end

	// next row and its active-low drive
	always_comb begin
		row_next = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
		q_entry.press_mask = press;
		q_entry.row        = row_q;
		q_entry.drive      = ~(DRIVE_W'(1) << row_next);
	end

	// history, stable state and row registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEYS; k++) begin
				hist_q[k] <= '1;
			end
			stable_q <= '1;
			row_q    <= '0;
		end else if (accept) begin
			for (int c = 0; c < COLUMNS; c++) begin
				hist_q[{row_q, COL_W'(c)}] <= hist_new[c];
				if (all_low[c]) begin
					stable_q[{row_q, COL_W'(c)}] <= 1'b0;
				end else if (all_high[c]) begin
					stable_q[{row_q, COL_W'(c)}] <= 1'b1;
				end
			end
			row_q <= row_next;
		end
	end

	// row advances by one, wrapping, on every accepted request
	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> row_q == (($past(row_q) == ROW_W'(ROWS - 1)) ? '0 : $past(row_q) + 1'b1))
		else $error("row index did not advance");

	// a reported press implies an all-low history for that key
	a_press_from_released: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && (q_entry.press_mask != '0)) |-> ((press & ~all_low) == '0))
		else $error("press reported without all-low history");

endmodule

/* sv/kbd_queue.sv */
// ----------------------------------------------------------------------------
// kbd_queue - short entry queue
// Two-entry register queue that decouples the scan front end from the
// result back end.
// ----------------------------------------------------------------------------
module kbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kbd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output kbd_pkg::entry_t head_entry
);
	import kbd_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

/* sv/kbd_back.sv */
// ----------------------------------------------------------------------------
// kbd_back - result sequencer and keymap
// Walks the head entry's press mask in ascending column order, one result
// per cycle unless out_ready stalls; looks up key codes, holds the keymap.
// ----------------------------------------------------------------------------
module kbd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           head_valid,
	input  kbd_pkg::entry_t                head_entry,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [kbd_pkg::DRIVE_W-1:0]    row_drive,
	output logic                           press_valid,
	output logic [kbd_pkg::KEY_W-1:0]      key_index,
	output logic [kbd_pkg::CODE_W-1:0]     key_code,
	output logic                           last
);
	import kbd_pkg::*;

	logic [2*CFG_DATA_W-1:0] keymap_q;
	logic [COLUMNS-1:0]      done_q;
	logic                    out_valid_q;

	logic [COLUMNS-1:0] remain;
	logic [COL_W-1:0]   col;
	logic [COLUMNS-1:0] col_bit;
	logic [KEY_W-1:0]   idx;
	logic               any;
	logic               is_last;
	logic               fire;

	// keymap registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keymap_q <= {KEYMAP_HIGH_RST, KEYMAP_LOW_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEYMAP_LOW:  keymap_q[CFG_DATA_W-1:0]            <= cfg_data;
				REG_KEYMAP_HIGH: keymap_q[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// lowest column still to report
	always_comb begin
		remain = head_entry.press_mask & ~done_q;
		col    = '0;
		for (int c = COLUMNS - 1; c >= 0; c--) begin
			if (remain[c]) begin
				col = COL_W'(c);
			end
		end
		col_bit = COLUMNS'(1) << col;
		any     = (remain != '0);
		is_last = ((remain & ~col_bit) == '0);
		idx     = {head_entry.row, col};
	end

	assign fire      = head_valid && (!out_valid_q || out_ready);
	assign pop       = fire && is_last;
	assign out_valid = out_valid_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				done_q      <= is_last ? '0 : (done_q | col_bit);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			row_drive   <= head_entry.drive;
			press_valid <= any;
			key_index   <= any ? idx : '0;
			key_code    <= any ? keymap_q[{idx, 3'b000} +: CODE_W] : '0;
			last        <= is_last;
		end
	end

	// popping an entry always leaves its final result in the register
	a_pop_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && last)
		else $error("entry popped without final result");

	// an empty tick result is a single zero result
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !press_valid) |-> (last && key_index == '0 && key_code == '0))
		else $error("malformed no-press result");

	// done mask only tracks columns of the head entry
	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((done_q & ~head_entry.press_mask) == '0))
		else $error("done mask outside press mask");

endmodule

/* sv/matrix_keypad_scan_debounce.sv */
// A request's entry is registered in the queue, and its first result is registered by the
// back end from the queue head once the result register is free or out_ready is high.
// One request per cycle when it causes no press and out_ready holds; a request with new
// presses gives one result per press, emitted one per cycle while out_ready holds.
// Reset: asynchronous, all keys released, row 0 driven next, keymap to its default codes.
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce - 4x4 keypad scanner with debounce
// Front end debounces each scan tick and classifies new presses, a short
// queue holds the ticks, and the back end emits the press results.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce #(
	parameter int DEBOUNCE_SAMPLES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [kbd_pkg::LEVEL_W-1:0]    column_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [kbd_pkg::DRIVE_W-1:0]    row_drive,
	output logic                           press_valid,
	output logic [kbd_pkg::KEY_W-1:0]      key_index,
	output logic [kbd_pkg::CODE_W-1:0]     key_code,
	output logic                           last
);
	import kbd_pkg::*;

	entry_t push_entry;
	entry_t head_entry;
	logic   push;
	logic   full;
	logic   pop;
	logic   head_valid;

	// scan intake and debounce
	kbd_front #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column_levels(column_levels),
		.q_full       (full),
		.q_push       (push),
		.q_entry      (push_entry)
	);

	// decoupling queue
	kbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	// result sequencing and keymap
	kbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_drive  (row_drive),
		.press_valid(press_valid),
		.key_index  (key_index),
		.key_code   (key_code),
		.last       (last)
	);

endmodule
